@@ design/pds_pkg.sv @@
// Shared types and constants for the PID drive step block.
package pds_pkg;

  localparam int ERR_W   = 25;
  localparam int INTEG_W = 48;
  localparam int ISAT_W  = 44;
  localparam int TOTAL_W = 62;

  localparam logic [2:0] CFG_TARGET         = 3'd0;
  localparam logic [2:0] CFG_KP_GAIN        = 3'd1;
  localparam logic [2:0] CFG_KI_GAIN        = 3'd2;
  localparam logic [2:0] CFG_KD_GAIN        = 3'd3;
  localparam logic [2:0] CFG_MAX_POWER      = 3'd4;
  localparam logic [2:0] CFG_TOLERANCE      = 3'd5;
  localparam logic [2:0] CFG_SETTLE_SAMPLES = 3'd6;
  localparam logic [2:0] CFG_DRIVE_MODE     = 3'd7;

  localparam logic [14:0] MIN_POWER  = 15'd1024;
  localparam logic [7:0]  SETTLE_MAX = 8'd255;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [23:0] target;
    logic [15:0]        kp_gain;
    logic [15:0]        ki_gain;
    logic [15:0]        kd_gain;
    logic [14:0]        max_power;
    logic [22:0]        tolerance;
    logic [7:0]         settle_samples;
    logic [1:0]         drive_mode;
  } pds_cfg_t;

  typedef struct packed {
    op_t                     op;
    logic                    in_tol;
    logic signed [ERR_W-1:0] err;
  } pds_item_t;

endpackage

@@ design/pds_front.sv @@
// Front end: forms the position error of an incoming beat and classifies it.
module pds_front (
  input  pds_pkg::pds_cfg_t  cfg,
  input  logic               op_bit,
  input  logic [23:0]        measured,
  output pds_pkg::pds_item_t item
);
  import pds_pkg::*;

  logic signed [15:0]      tgt_units;
  logic signed [15:0]      tgt_units_adj;
  logic signed [ERR_W-1:0] tgt_whole;
  logic signed [ERR_W-1:0] meas_ext;
  logic signed [ERR_W-1:0] err;
  logic [ERR_W-1:0]        err_mag;

  // The target's fraction is dropped toward zero.
  assign tgt_units     = cfg.target[23:8];
  assign tgt_units_adj = (cfg.target[23] && (cfg.target[7:0] != 8'h00)) ?
                         tgt_units + 16'sd1 : tgt_units;
  assign tgt_whole     = $signed({tgt_units_adj[15], tgt_units_adj, 8'h00});
  assign meas_ext      = $signed({measured[23], measured});
  assign err           = tgt_whole - meas_ext;
  assign err_mag       = err[ERR_W-1] ? ERR_W'(-err) : err;

  assign item.op     = op_t'(op_bit);
  assign item.in_tol = (err_mag <= {2'b00, cfg.tolerance});
  assign item.err    = err;

endmodule

@@ design/pds_queue.sv @@
// Small FIFO of classified items between the front end and the back end.
module pds_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  pds_pkg::pds_item_t wr_item,
  output logic               full,
  input  logic               rd_en,
  output pds_pkg::pds_item_t rd_item,
  output logic               empty
);
  import pds_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pds_item_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/pds_back.sv @@
// Back end: controller state, gain products, clamp and output register.
module pds_back (
  input  logic               clk,
  input  logic               rst,
  input  pds_pkg::pds_cfg_t  cfg,
  input  logic               item_valid,
  input  pds_pkg::pds_item_t item,
  output logic               pop,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [15:0]        left_power,
  output logic [15:0]        right_power,
  output logic               done_res
);
  import pds_pkg::*;

  logic                      en;

  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [ERR_W-1:0]   previous_error;
  logic [7:0]                settle_count;
  logic                      finished;

  logic signed [INTEG_W:0]   integ_wide;
  logic signed [INTEG_W-1:0] integ_next;
  logic signed [ERR_W:0]     delta;
  logic [7:0]                settle_next;
  logic [7:0]                need;
  logic                      fin;
  logic signed [ISAT_W-1:0]  isat;

  logic                      a_valid, a_zero, a_done, a_neg;
  logic signed [ERR_W-1:0]   a_err;
  logic signed [ERR_W:0]     a_delta;
  logic signed [ISAT_W-1:0]  a_isat;

  logic                      b_valid, b_zero, b_done, b_neg;
  logic signed [41:0]        b_p;
  logic signed [42:0]        b_d;
  logic [37:0]               b_ilo;
  logic signed [38:0]        b_ihi;

  logic                      c_valid, c_zero, c_done, c_neg;
  logic signed [TOTAL_W-1:0] c_isum;
  logic signed [43:0]        c_pd;

  logic                      d_valid, d_zero, d_done, d_neg;
  logic signed [TOTAL_W-1:0] d_total;

  logic signed [TOTAL_W-1:0] cap_pos;
  logic signed [TOTAL_W-1:0] cap_neg;
  logic signed [TOTAL_W-1:0] floor_pos;
  logic signed [TOTAL_W-1:0] floor_neg;
  logic                      over;
  logic                      under;
  logic [23:0]               total_low;
  logic [23:0]               mag;
  logic [14:0]               pwr_mag;
  logic signed [15:0]        pwr;
  logic signed [15:0]        left_pwr;

  assign en  = !out_valid || out_ready;
  assign pop = en && item_valid;

  always_comb begin
    integ_wide = $signed({integral_sum[INTEG_W-1], integral_sum}) +
                 $signed({{(INTEG_W - ERR_W + 1){item.err[ERR_W-1]}}, item.err});
    if (integ_wide[INTEG_W] != integ_wide[INTEG_W-1]) begin
      integ_next = integ_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} :
                                         {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_next = integ_wide[INTEG_W-1:0];
    end

    // Beyond this range the integral term dwarfs every clamp level.
    if (integ_next[INTEG_W-1:ISAT_W-1] == '0 ||
        integ_next[INTEG_W-1:ISAT_W-1] == '1) begin
      isat = integ_next[ISAT_W-1:0];
    end else if (integ_next[INTEG_W-1]) begin
      isat = {1'b1, {(ISAT_W-1){1'b0}}};
    end else begin
      isat = {1'b0, {(ISAT_W-1){1'b1}}};
    end

    delta = $signed({item.err[ERR_W-1], item.err}) -
            $signed({previous_error[ERR_W-1], previous_error});

    if (item.in_tol) begin
      settle_next = (settle_count == SETTLE_MAX) ? settle_count : settle_count + 8'd1;
    end else begin
      settle_next = '0;
    end
    need = (cfg.settle_samples == 8'd0) ? 8'd1 : cfg.settle_samples;
    fin  = (settle_next >= need);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
      settle_count   <= '0;
      finished       <= 1'b0;
    end else if (pop) begin
      if (item.op == OP_START) begin
        integral_sum   <= '0;
        previous_error <= '0;
        settle_count   <= '0;
        finished       <= 1'b0;
      end else if (!finished) begin
        integral_sum   <= integ_next;
        previous_error <= item.err;
        settle_count   <= settle_next;
        if (fin) begin
          finished <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_err   <= item.err;
      a_delta <= delta;
      a_isat  <= isat;
      a_neg   <= item.err[ERR_W-1];
      if (item.op == OP_START) begin
        a_zero <= 1'b1;
        a_done <= 1'b0;
      end else if (finished) begin
        a_zero <= 1'b1;
        a_done <= 1'b1;
      end else begin
        a_zero <= fin;
        a_done <= fin;
      end

      b_p   <= a_err * $signed({1'b0, cfg.kp_gain});
      b_d   <= a_delta * $signed({1'b0, cfg.kd_gain});
      b_ilo <= a_isat[21:0] * cfg.ki_gain;
      b_ihi <= $signed(a_isat[ISAT_W-1:22]) * $signed({1'b0, cfg.ki_gain});
      b_zero <= a_zero;
      b_done <= a_done;
      b_neg  <= a_neg;

      c_isum <= ($signed({{23{b_ihi[38]}}, b_ihi}) <<< 22) + $signed({24'b0, b_ilo});
      c_pd   <= $signed({{2{b_p[41]}}, b_p}) + $signed({b_d[42], b_d});
      c_zero <= b_zero;
      c_done <= b_done;
      c_neg  <= b_neg;

      d_total <= c_isum + $signed({{(TOTAL_W - 44){c_pd[43]}}, c_pd});
      d_zero  <= c_zero;
      d_done  <= c_done;
      d_neg   <= c_neg;
    end
  end

  always_comb begin
    cap_pos   = $signed({{(TOTAL_W - 23){1'b0}}, cfg.max_power, 8'h00});
    cap_neg   = -cap_pos;
    floor_pos = $signed({{(TOTAL_W - 23){1'b0}}, MIN_POWER, 8'h00});
    floor_neg = -floor_pos;
    over      = (d_total > cap_pos) || (d_total < cap_neg);
    under     = (d_total < floor_pos) && (d_total > floor_neg);
    total_low = d_total[23:0];
    mag       = total_low[23] ? 24'(-total_low) : total_low;
    if (over) begin
      pwr_mag = cfg.max_power;
    end else if (under) begin
      pwr_mag = MIN_POWER;
    end else begin
      pwr_mag = mag[22:8];
    end
    pwr      = (d_neg ^ cfg.drive_mode[1]) ? -$signed({1'b0, pwr_mag}) :
                                              $signed({1'b0, pwr_mag});
    left_pwr = cfg.drive_mode[0] ? -pwr : pwr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= item_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      left_power  <= d_zero ? 16'h0000 : left_pwr;
      right_power <= d_zero ? 16'h0000 : pwr;
      done_res    <= d_done;
    end
  end

endmodule

@@ design/pid_drive_step_with_settle_top.sv @@
// Top level of the PID drive step block with output clamp and settle detection.
//
// While the output is not stalled, the block takes one beat per clock cycle and
// returns one result beat for each, in order. An accepted beat enters a queue of
// QUEUE_DEPTH entries; the back end takes one entry per cycle unless the output
// stalls, and its result passes through stages a, b, c, d and the output register.
// The back end's update of the integrator, previous error and settle count sets
// the rate; the three gain products and the clamp follow it. Input tready falls
// only when the queue is full because the output side is stalled. Configuration
// is to be written only while no beat is in flight; the block does not enforce it.
module pid_drive_step_with_settle_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // measured[23:0]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // left_power[15:0], right_power[31:16]
  output logic        m_axis_tuser,   // done_res
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import pds_pkg::*;

  pds_cfg_t  cfg;
  pds_item_t front_item;
  pds_item_t queue_item;
  logic      queue_full;
  logic      queue_empty;
  logic      pop;
  logic [15:0] left_power;
  logic [15:0] right_power;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target         <= '0;
      cfg.kp_gain        <= 16'd1280;
      cfg.ki_gain        <= '0;
      cfg.kd_gain        <= '0;
      cfg.max_power      <= 15'd25600;
      cfg.tolerance      <= 23'd128;
      cfg.settle_samples <= 8'd6;
      cfg.drive_mode     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TARGET:         cfg.target         <= $signed(cfg_data);
        CFG_KP_GAIN:        cfg.kp_gain        <= cfg_data[15:0];
        CFG_KI_GAIN:        cfg.ki_gain        <= cfg_data[15:0];
        CFG_KD_GAIN:        cfg.kd_gain        <= cfg_data[15:0];
        CFG_MAX_POWER:      cfg.max_power      <= cfg_data[14:0];
        CFG_TOLERANCE:      cfg.tolerance      <= cfg_data[22:0];
        CFG_SETTLE_SAMPLES: cfg.settle_samples <= cfg_data[7:0];
        CFG_DRIVE_MODE:     cfg.drive_mode     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  pds_front u_front (
    .cfg      (cfg),
    .op_bit   (s_axis_tuser),
    .measured (s_axis_tdata),
    .item     (front_item)
  );

  pds_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (s_axis_tvalid),
    .wr_item (front_item),
    .full    (queue_full),
    .rd_en   (pop),
    .rd_item (queue_item),
    .empty   (queue_empty)
  );

  assign s_axis_tready = !queue_full;

  pds_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (!queue_empty),
    .item        (queue_item),
    .pop         (pop),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .left_power  (left_power),
    .right_power (right_power),
    .done_res    (m_axis_tuser)
  );

  assign m_axis_tdata = {right_power, left_power};

endmodule

@@ design/pds_checker.sv @@
// Port-level checks for the PID drive step block and their bind to the top level.
module pds_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("outputs not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'h0000_0000)
    else $error("settled beat carries drive");

  a_sides_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[15:0] == m_axis_tdata[31:16]) ||
                      (m_axis_tdata[15:0] == 16'(~m_axis_tdata[31:16] + 16'd1)))
    else $error("left and right drive magnitudes differ");

endmodule

bind pid_drive_step_with_settle_top pds_checker u_pds_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ test/pid_drive_step_with_settle_top_test.sv @@
`timescale 1ns / 100ps
// Self-checking stream test of the PID drive step block with a cycle-free model of the loop.
module pid_drive_step_with_settle_top_test;
  import pds_pkg::*;

  localparam longint INTEG_HI    = 64'sd140737488355327;
  localparam longint INTEG_LO    = -64'sd140737488355328;
  localparam longint TERM_CAP    = 64'sd1125899906842624;
  localparam int     PHASES      = 10;
  localparam int     PHASE_ITEMS = 120;
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     PRINT_CAP   = 200;

  typedef struct packed {
    logic               done;
    logic signed [15:0] right;
    logic signed [15:0] left;
  } drive_beat_t;

  class drive_scoreboard;
    pds_cfg_t    cfg;
    longint      integ;
    longint      last_err;
    int          settle_cnt;
    bit          finished;
    drive_beat_t drive_q[$];
    int          fails;

    function new();
      cfg = '{target: '0, kp_gain: 16'd1280, ki_gain: '0, kd_gain: '0,
              max_power: 15'd25600, tolerance: 23'd128, settle_samples: 8'd6,
              drive_mode: '0};
      integ = 0;
      last_err = 0;
      settle_cnt = 0;
      finished = 1'b0;
      fails = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        CFG_TARGET:         cfg.target = val;
        CFG_KP_GAIN:        cfg.kp_gain = val[15:0];
        CFG_KI_GAIN:        cfg.ki_gain = val[15:0];
        CFG_KD_GAIN:        cfg.kd_gain = val[15:0];
        CFG_MAX_POWER:      cfg.max_power = val[14:0];
        CFG_TOLERANCE:      cfg.tolerance = val[22:0];
        CFG_SETTLE_SAMPLES: cfg.settle_samples = val[7:0];
        CFG_DRIVE_MODE:     cfg.drive_mode = val[1:0];
        default: ;
      endcase
    endfunction

    // The setpoint fraction is dropped toward zero.
    function longint whole_target();
      longint t;
      t = longint'($signed(cfg.target));
      return (t >= 0) ? (t & ~longint'(255)) : -((-t) & ~longint'(255));
    endfunction

    function int settle_need();
      return (cfg.settle_samples == 0) ? 1 : int'(cfg.settle_samples);
    endfunction

    function int pending();
      return drive_q.size();
    endfunction

    function void note_sample(op_t op, logic [23:0] meas);
      longint      err;
      longint      delta;
      longint      iterm;
      longint      total;
      longint      mag;
      longint      pwr;
      longint      lft;
      drive_beat_t want;
      want = '0;
      if (op == OP_START) begin
        integ = 0;
        last_err = 0;
        settle_cnt = 0;
        finished = 1'b0;
      end else if (finished) begin
        want.done = 1'b1;
      end else begin
        err = whole_target() - longint'($signed(meas));
        integ += err;
        if (integ > INTEG_HI) integ = INTEG_HI;
        if (integ < INTEG_LO) integ = INTEG_LO;
        delta = err - last_err;
        last_err = err;
        iterm = integ * longint'(cfg.ki_gain);
        if (iterm > TERM_CAP) iterm = TERM_CAP;
        if (iterm < -TERM_CAP) iterm = -TERM_CAP;
        total = err * longint'(cfg.kp_gain) + iterm + delta * longint'(cfg.kd_gain);
        mag = (total < 0) ? -total : total;
        if (mag > longint'(cfg.max_power) * 256) pwr = longint'(cfg.max_power);
        else if (mag < longint'(MIN_POWER) * 256) pwr = longint'(MIN_POWER);
        else pwr = mag / 256;
        if ((err < 0) != cfg.drive_mode[1]) pwr = -pwr;
        lft = cfg.drive_mode[0] ? -pwr : pwr;
        if (((err < 0) ? -err : err) <= longint'(cfg.tolerance)) begin
          if (settle_cnt < SETTLE_MAX) settle_cnt++;
        end else begin
          settle_cnt = 0;
        end
        if (settle_cnt >= settle_need()) begin
          finished = 1'b1;
          want.done = 1'b1;
        end else begin
          want.left = lft[15:0];
          want.right = pwr[15:0];
        end
      end
      drive_q.push_back(want);
    endfunction

    function void report(string field, longint want, longint got);
      fails++;
      if (fails <= PRINT_CAP)
        $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    endfunction

    function void check_result(logic [31:0] data, logic done);
      drive_beat_t want;
      if (drive_q.size() == 0) begin
        fails++;
        if (fails <= PRINT_CAP)
          $display("%0t: result beat with none expected, data %h done %b", $time, data, done);
        return;
      end
      want = drive_q.pop_front();
      if (data[15:0] !== want.left) report("left_power", want.left, $signed(data[15:0]));
      if (data[31:16] !== want.right) report("right_power", want.right, $signed(data[31:16]));
      if (done !== want.done) report("done_res", want.done, done);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // measured[23:0]
  logic        s_axis_tuser;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // left_power[15:0], right_power[31:16]
  logic        m_axis_tuser;   // done_res
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  drive_scoreboard sb;
  bit              idling = 1'b1;
  bit              tx_quiet = 1'b0;
  int              items_sent = 0;
  int              phase_start;
  int              cycles = 0;

  pid_drive_step_with_settle_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  always begin
    @(negedge clk);
    if (idling && $urandom_range(0, 6) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end else if (idling && $urandom_range(0, 40) == 0) begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(20, 80)) @(negedge clk);
    end
    m_axis_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(op_t'(s_axis_tuser), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [23:0] pos24(longint v);
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[23:0];
  endfunction

  task automatic send_beat(op_t op, logic [23:0] meas);
    int gap;
    gap = (idling && !tx_quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= meas;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic wait_for_drive_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic load_reg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_phase_gains(int p);
    logic [23:0] tgt;
    logic [23:0] kp;
    logic [23:0] ki;
    logic [23:0] kd;
    logic [23:0] cap;
    logic [23:0] tol;
    logic [23:0] need;
    logic [23:0] mode;
    if (p == 0) begin
      tgt = 24'h7FFFFF; kp = 24'hFFFF; ki = 24'hFFFF; kd = 24'hFFFF;
      cap = 24'h7FFF; tol = 24'h7FFFFF; need = 24'd255; mode = 24'd3;
    end else if (p == 1) begin
      tgt = 24'h800000; kp = '0; ki = '0; kd = '0;
      cap = '0; tol = '0; need = '0; mode = '0;
    end else begin
      tgt = 24'($urandom);
      kp = 24'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) :
                                              $urandom_range(64, 4096));
      ki = 24'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) :
                                              $urandom_range(0, 32));
      kd = 24'($urandom_range(0, 65535));
      case ($urandom_range(0, 5))
        0:       cap = 24'd0;
        1:       cap = 24'd1023;
        2:       cap = 24'd1024;
        3:       cap = 24'd25600;
        4:       cap = 24'd32767;
        default: cap = 24'($urandom_range(0, 32767));
      endcase
      tol = 24'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8388607) :
                                               $urandom_range(0, 2048));
      need = 24'($urandom_range(1, 8));
      mode = 24'($urandom_range(0, 3));
    end
    load_reg(CFG_TARGET, tgt);
    load_reg(CFG_KP_GAIN, kp);
    load_reg(CFG_KI_GAIN, ki);
    load_reg(CFG_KD_GAIN, kd);
    load_reg(CFG_MAX_POWER, cap);
    load_reg(CFG_TOLERANCE, tol);
    load_reg(CFG_SETTLE_SAMPLES, need);
    load_reg(CFG_DRIVE_MODE, mode);
  endtask

  // A move starts, closes in on the setpoint from far away, then mostly sits in the band.
  task automatic run_move(int approach, int settle_n);
    longint tw;
    longint tol;
    longint off;
    tw = sb.whole_target();
    tol = longint'(sb.cfg.tolerance);
    send_beat(OP_START, 24'($urandom));
    for (int i = approach; i > 0; i--) begin
      off = longint'($urandom_range(1, 65535)) * i + tol;
      send_beat(OP_SAMPLE, pos24($urandom_range(0, 1) ? tw - off : tw + off));
    end
    for (int i = 0; i < settle_n; i++) begin
      case ($urandom_range(0, 15))
        0:       off = tol + 1 + $urandom_range(0, 255);
        1:       off = tol;
        2:       off = 0;
        default: off = $urandom_range(0, int'(tol));
      endcase
      send_beat(OP_SAMPLE, pos24($urandom_range(0, 1) ? tw - off : tw + off));
    end
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_TARGET;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_beat(OP_SAMPLE, 24'h000000);
    send_beat(OP_START, 24'h000000);
    send_beat(OP_SAMPLE, 24'h7FFFFF);
    send_beat(OP_SAMPLE, 24'h800000);
    send_beat(OP_SAMPLE, 24'h000100);
    send_beat(OP_SAMPLE, 24'h000000);
    send_beat(OP_SAMPLE, 24'h000050);
    send_beat(OP_SAMPLE, 24'hFFFFB0);
    send_beat(OP_SAMPLE, 24'h000080);
    send_beat(OP_SAMPLE, 24'hFFFF80);
    send_beat(OP_SAMPLE, 24'h000000);
    send_beat(OP_SAMPLE, 24'h000005);

    wait_for_drive_results();
    load_reg(CFG_MAX_POWER, 24'd512);
    load_reg(CFG_DRIVE_MODE, 24'd3);
    load_reg(CFG_SETTLE_SAMPLES, 24'd0);
    load_reg(CFG_TARGET, 24'hFFFED4);
    send_beat(OP_START, 24'h000000);
    send_beat(OP_SAMPLE, 24'h000000);
    send_beat(OP_SAMPLE, 24'hFFFEF6);
    send_beat(OP_SAMPLE, 24'hFFFF00);

    wait_for_drive_results();
    load_reg(CFG_DRIVE_MODE, 24'd1);
    load_reg(CFG_KI_GAIN, 24'hFFFF);
    load_reg(CFG_KD_GAIN, 24'hFFFF);
    load_reg(CFG_MAX_POWER, 24'd25600);
    send_beat(OP_START, 24'h000000);
    send_beat(OP_SAMPLE, 24'h800000);
    send_beat(OP_SAMPLE, 24'h7FFFFF);
    send_beat(OP_SAMPLE, 24'h800000);

    for (int p = 0; p < PHASES; p++) begin
      if (p >= PHASES - 2) idling = 1'b0;
      wait_for_drive_results();
      load_phase_gains(p);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        tx_quiet = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) < 7)
          run_move($urandom_range(0, 10), sb.settle_need() + $urandom_range(0, 3));
        else
          repeat ($urandom_range(1, 6))
            send_beat(($urandom_range(0, 3) == 0) ? OP_START : OP_SAMPLE, 24'($urandom));
        if ($urandom_range(0, 30) == 0) wait_for_drive_results();
      end
    end

    wait_for_drive_results();
    if (sb.fails == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
